/* rtl/eep_pkg.sv */
// Shared types and constants for the emergency error producer.
// Used by eep_ctrl, eep_dp and emergency_error_producer; no dependencies.
package eep_pkg;

   localparam int MAX_ACTIVE_DEF    = 8;
   localparam int HISTORY_DEPTH_DEF = 8;
   localparam int QUEUE_DEPTH_DEF   = 8;

   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 96;

   localparam logic [15:0] INHIBIT_RESET = 16'd0;
   localparam logic [31:0] COB_ID_RESET  = 32'd128;
   // (x + 9) / 10 as (x + 9) * 0xCCCD >> 19, exact below 81920
   localparam logic [16:0] ROUND_ADD = 17'd9;
   localparam logic [15:0] RECIP_10  = 16'hCCCD;
   localparam int          RECIP_SH  = 19;

   typedef enum logic [1:0] {
      REQ_RAISE    = 2'd0,
      REQ_CLEAR    = 2'd1,
      REQ_CLEARALL = 2'd2,
      REQ_TICK     = 2'd3
   } req_kind_type;

   typedef enum logic {
      CSR_INHIBIT = 1'b0,
      CSR_COB_ID  = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic emit;
   } cmd_type;

endpackage

/* rtl/eep_ctrl.sv */
// Sequencer of the emergency error producer: input capture, update, result.
// Depends on eep_pkg.
module eep_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output eep_pkg::cmd_type cmd
);
   import eep_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // wait for the result register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = cmd.emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_load_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.exec)
      else $error("update did not follow capture");
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_tvalid)
      else $error("result not presented after emit");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second item accepted while busy");

endmodule

/* rtl/eep_dp.sv */
// Datapath: active table, error history, frame ring, inhibit timer, CSRs.
// Depends on eep_pkg; driven by commands from eep_ctrl.
module eep_dp #(
   parameter int MAX_ACTIVE    = eep_pkg::MAX_ACTIVE_DEF,
   parameter int HISTORY_DEPTH = eep_pkg::HISTORY_DEPTH_DEF,
   parameter int QUEUE_DEPTH   = eep_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  eep_pkg::cmd_type                cmd,
   input  logic                            csr_write,
   input  logic                            csr_index,
   input  logic [31:0]                     csr_data,
   input  logic [eep_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [1:0]                      req_tuser,
   output logic [eep_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import eep_pkg::*;

   localparam int CW = $clog2(MAX_ACTIVE + 1);
   localparam int IW = (MAX_ACTIVE > 1) ? $clog2(MAX_ACTIVE) : 1;
   localparam int HW = $clog2(HISTORY_DEPTH + 1);
   localparam int QW = $clog2(QUEUE_DEPTH);

   logic [15:0] inhibit_ff, inhibit_in;
   logic [31:0] cob_ff, cob_in;
   logic [13:0] gap_ff, gap_in;

   logic [1:0]  kind_ff;
   logic [15:0] code_ff;
   logic [7:0]  rbits_ff;
   logic [39:0] info_ff;
   logic [31:0] now_ff;
   logic        txrdy_ff;

   logic [15:0] codes_ff [MAX_ACTIVE];
   logic [15:0] codes_in [MAX_ACTIVE];
   logic [7:0]  bits_ff  [MAX_ACTIVE];
   logic [7:0]  bits_in  [MAX_ACTIVE];
   logic [CW-1:0] count_ff, count_in;

   logic [31:0] hist_ff [HISTORY_DEPTH];
   logic [31:0] hist_in [HISTORY_DEPTH];
   logic [HW-1:0] fill_ff, fill_in;

   logic [63:0] queue_ff [QUEUE_DEPTH];
   logic [QW-1:0] head_ff, head_in, tail_ff, tail_in, head_nx, tail_nx;
   logic [31:0] until_ff, until_in;

   logic        sent_ff, sent_in, drop_ff, drop_in;
   logic [10:0] fid_ff, fid_in;
   logic [63:0] fdata_ff, fdata_in;
   logic [RSP_DATA_W-1:0] rsp_ff, rsp_in;

   logic        found;
   logic [IW-1:0] pos;
   logic [7:0]  reg_now;
   logic        push;
   logic [63:0] push_frame;
   logic        blocked;
   logic [32:0] prod;
   logic [31:0] diff;

   // inhibit gap in ms, recomputed each cycle from the CSR
   always_comb begin
      prod   = 33'(({1'b0, inhibit_ff} + ROUND_ADD) * RECIP_10);
      gap_in = prod[RECIP_SH +: 14];
   end

   // table search and error register over the current contents
   always_comb begin
      found   = 1'b0;
      pos     = '0;
      reg_now = (count_ff != '0) ? 8'h01 : 8'h00;
      for (int i = MAX_ACTIVE - 1; i >= 0; i--) begin
         if (CW'(i) < count_ff) begin
            reg_now = reg_now | bits_ff[i];
            if (codes_ff[i] == code_ff) begin
               found = 1'b1;
               pos   = IW'(i);
            end
         end
      end
   end

   assign head_nx = (head_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign tail_nx = (tail_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
   assign diff    = now_ff - until_ff;
   assign blocked = (inhibit_ff != '0) && diff[31];

   always_comb begin
      codes_in   = codes_ff;
      bits_in    = bits_ff;
      count_in   = count_ff;
      hist_in    = hist_ff;
      fill_in    = fill_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      until_in   = until_ff;
      sent_in    = sent_ff;
      drop_in    = drop_ff;
      fid_in     = fid_ff;
      fdata_in   = fdata_ff;
      push       = 1'b0;
      push_frame = '0;
      if (cmd.exec) begin
         sent_in  = 1'b0;
         drop_in  = 1'b0;
         fid_in   = '0;
         fdata_in = '0;
         case (kind_ff)
            REQ_RAISE: begin
               if (!found) begin
                  if (count_ff < CW'(MAX_ACTIVE)) begin
                     codes_in[count_ff[IW-1:0]] = code_ff;
                     bits_in[count_ff[IW-1:0]]  = rbits_ff;
                     count_in = count_ff + 1'b1;
                     push_frame = {info_ff, reg_now | rbits_ff | 8'h01, code_ff};
                  end else begin
                     push_frame = {info_ff, reg_now, code_ff};
                  end
                  if (fill_ff < HW'(HISTORY_DEPTH)) fill_in = fill_ff + 1'b1;
                  for (int j = HISTORY_DEPTH - 1; j > 0; j--) begin
                     hist_in[j] = hist_ff[j - 1];
                  end
                  hist_in[0] = {info_ff[15:0], code_ff};
                  push = 1'b1;
               end
            end
            REQ_CLEAR: begin
               if (found) begin
                  // close the gap left by the removed code
                  for (int j = 0; j < MAX_ACTIVE - 1; j++) begin
                     if (IW'(j) >= pos) begin
                        codes_in[j] = codes_ff[j + 1];
                        bits_in[j]  = bits_ff[j + 1];
                     end
                  end
                  count_in = count_ff - 1'b1;
                  if (count_ff == CW'(1)) begin
                     push       = 1'b1;
                     push_frame = {24'd0, code_ff, 8'd0, 16'd0};
                  end
               end
            end
            REQ_CLEARALL: begin
               if (count_ff != '0) begin
                  count_in   = '0;
                  push       = 1'b1;
                  push_frame = {24'd0, codes_ff[0], 8'd0, 16'd0};
               end
            end
            REQ_TICK: begin
               if (head_ff != tail_ff && !blocked) begin
                  if (cob_ff[31]) begin
                     tail_in = head_ff;
                  end else if (txrdy_ff) begin
                     sent_in  = 1'b1;
                     fid_in   = cob_ff[10:0];
                     fdata_in = queue_ff[tail_ff];
                     tail_in  = tail_nx;
                     if (inhibit_ff != '0) until_in = now_ff + 32'(gap_ff);
                  end
               end
            end
            default: ;
         endcase
         if (push) begin
            if (head_nx == tail_ff) drop_in = 1'b1;
            else                    head_in = head_nx;
         end
      end
   end

   // result from the updated state
   always_comb begin
      logic act;
      logic [7:0] r;
      act = 1'b0;
      r   = (count_ff != '0) ? 8'h01 : 8'h00;
      for (int i = 0; i < MAX_ACTIVE; i++) begin
         if (CW'(i) < count_ff) begin
            r = r | bits_ff[i];
            if (codes_ff[i] == code_ff) act = 1'b1;
         end
      end
      rsp_in = cmd.emit ?
         {6'd0, drop_ff, 4'(fill_ff), act, r, fdata_ff, fid_ff, sent_ff} : rsp_ff;
   end

   always_comb begin
      inhibit_in = inhibit_ff;
      cob_in     = cob_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_INHIBIT: inhibit_in = csr_data[15:0];
            CSR_COB_ID:  cob_in     = csr_data;
            default: ;
         endcase
      end
   end

   assign rsp_tdata = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inhibit_ff <= INHIBIT_RESET;
         cob_ff     <= COB_ID_RESET;
         count_ff   <= '0;
         fill_ff    <= '0;
         head_ff    <= '0;
         tail_ff    <= '0;
         until_ff   <= '0;
      end else begin
         inhibit_ff <= inhibit_in;
         cob_ff     <= cob_in;
         count_ff   <= count_in;
         fill_ff    <= fill_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         until_ff   <= until_in;
      end
   end

   always_ff @(posedge clock) begin
      gap_ff   <= gap_in;
      codes_ff <= codes_in;
      bits_ff  <= bits_in;
      hist_ff  <= hist_in;
      sent_ff  <= sent_in;
      drop_ff  <= drop_in;
      fid_ff   <= fid_in;
      fdata_ff <= fdata_in;
      rsp_ff   <= rsp_in;
      if (push && !drop_in) queue_ff[head_ff] <= push_frame;
      if (cmd.load) begin
         kind_ff  <= req_tuser;
         code_ff  <= req_tdata[15:0];
         rbits_ff <= req_tdata[23:16];
         info_ff  <= req_tdata[63:24];
         now_ff   <= req_tdata[95:64];
         txrdy_ff <= req_tdata[96];
      end
   end

endmodule

/* rtl/emergency_error_producer.sv */
// Emergency message producer: one result item per request item.
// The result is registered by the emit step, which follows the update step; a new request
// is accepted only once the controller's three-state sequence is back in idle; a waiting
// result stalls only the emit step.
// Reset (synchronous): empties table, history and frame ring, clears inhibit
// timer, inhibit_time to 0 and the frame identifier register to 128.
module emergency_error_producer #(
   parameter int MAX_ACTIVE    = eep_pkg::MAX_ACTIVE_DEF,
   parameter int HISTORY_DEPTH = eep_pkg::HISTORY_DEPTH_DEF,
   parameter int QUEUE_DEPTH   = eep_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // error_code, reg_bit, error_info, now_ms, tx_ready, zero pad
   input  logic [eep_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_type
   input  logic [1:0]                     req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // frame_sent, frame_id, frame_data, error_register, code_active,
   // history_count, frame_dropped, zero pad
   output logic [eep_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic                           csr_index,
   input  logic [31:0]                    csr_data
);
   import eep_pkg::*;

   cmd_type cmd;

   assign csr_ready = 1'b1;

   eep_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   eep_dp #(
      .MAX_ACTIVE    (MAX_ACTIVE),
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .QUEUE_DEPTH   (QUEUE_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .csr_write (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata)
   );

endmodule

/* test/tb_emergency_error_producer.sv */
// Testbench for emergency_error_producer: random and directed request items,
// self-checking against an in-bench predictor of table, history, frame ring and inhibit.
// Depends on eep_pkg and the emergency_error_producer RTL.
`timescale 1ns / 1ps

module tb_emergency_error_producer;
   import eep_pkg::*;

   localparam int NACT = 8;
   localparam int NHIST = 8;
   localparam int NQ = 8;
   localparam int LIMIT = 400000;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] code;
      logic [7:0]  rbits;
      logic [39:0] info;
      logic [31:0] now;
      logic        txr;
   } req_item_t;

   // highest field first, so the packed layout matches rsp_tdata
   typedef struct packed {
      logic        dropped;
      logic [3:0]  hcount;
      logic        active;
      logic [7:0]  ereg;
      logic [63:0] fdata;
      logic [10:0] fid;
      logic        sent;
   } rsp_item_t;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_valid = 0;
   logic csr_ready;
   logic csr_index = 0;
   logic [31:0] csr_data = '0;

   emergency_error_producer dut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // predictor state
   logic [15:0] tbl_code [NACT];
   logic [7:0]  tbl_bits [NACT];
   int          tbl_n;
   int          hist_n;
   logic [63:0] ring [NQ];
   int          ring_wr, ring_rd;
   logic [31:0] quiet_until;
   logic [15:0] inhibit_cfg;
   logic [31:0] cob_cfg;

   req_item_t pending_reqs[$];
   rsp_item_t expected_rsps[$];
   int errors = 0;
   int cycles = 0;
   int hold_off = 0;
   bit stim_done = 0;

   function automatic logic [7:0] err_register();
      logic [7:0] r = 0;
      for (int i = 0; i < tbl_n; i++) r |= tbl_bits[i];
      if (tbl_n != 0) r |= 8'h01;
      return r;
   endfunction

   function automatic int lookup(logic [15:0] c);
      for (int i = 0; i < tbl_n; i++) if (tbl_code[i] == c) return i;
      return -1;
   endfunction

   function automatic logic push_frame(logic [15:0] c, logic [7:0] r, logic [39:0] inf);
      int nxt = (ring_wr + 1) % NQ;
      if (nxt == ring_rd) return 1;
      ring[ring_wr] = {inf, r, c};
      ring_wr = nxt;
      return 0;
   endfunction

   function automatic rsp_item_t predict_emcy(req_item_t q);
      rsp_item_t o;
      int pos;
      logic [15:0] oldest;
      o = '0;
      case (req_kind_type'(q.kind))
         REQ_RAISE: begin
            if (lookup(q.code) < 0) begin
               if (tbl_n < NACT) begin
                  tbl_code[tbl_n] = q.code;
                  tbl_bits[tbl_n] = q.rbits;
                  tbl_n++;
               end
               if (hist_n < NHIST) hist_n++;
               o.dropped = push_frame(q.code, err_register(), q.info);
            end
         end
         REQ_CLEAR: begin
            pos = lookup(q.code);
            if (pos >= 0) begin
               for (int k = pos + 1; k < tbl_n; k++) begin
                  tbl_code[k-1] = tbl_code[k];
                  tbl_bits[k-1] = tbl_bits[k];
               end
               tbl_n--;
               if (tbl_n == 0) o.dropped = push_frame(16'd0, 8'd0, {24'd0, q.code});
            end
         end
         REQ_CLEARALL: begin
            if (tbl_n != 0) begin
               oldest = tbl_code[0];
               tbl_n = 0;
               o.dropped = push_frame(16'd0, 8'd0, {24'd0, oldest});
            end
         end
         default: begin
            if (ring_wr != ring_rd &&
                !(inhibit_cfg != 0 && ((q.now - quiet_until) & 32'h8000_0000) != 0)) begin
               if (cob_cfg[31]) ring_rd = ring_wr;
               else if (q.txr) begin
                  o.sent = 1;
                  o.fid = cob_cfg[10:0];
                  o.fdata = ring[ring_rd];
                  ring_rd = (ring_rd + 1) % NQ;
                  if (inhibit_cfg != 0)
                     quiet_until = q.now + (32'(inhibit_cfg) + 9) / 10;
               end
            end
         end
      endcase
      o.ereg = err_register();
      o.active = lookup(q.code) >= 0;
      o.hcount = 4'(hist_n);
      return o;
   endfunction

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_tready) begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 3) != 0) begin
               req_item_t q;
               q = pending_reqs.pop_front();
               req_tvalid <= 1;
               req_tuser <= q.kind;
               req_tdata <= {7'd0, q.txr, q.now, q.info, q.rbits, q.code};
               expected_rsps.push_back(predict_emcy(q));
            end else begin
               req_tvalid <= 0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_item_t got, exp;
      cycles <= cycles + 1;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[89:0];
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected result %h", $time, got);
               errors <= errors + 1;
            end else begin
               exp = expected_rsps.pop_front();
               if (got !== exp) begin
                  $display("%0t: expected sent=%b id=%h data=%h reg=%h act=%b hc=%0d drop=%b",
                           $time, exp.sent, exp.fid, exp.fdata, exp.ereg, exp.active,
                           exp.hcount, exp.dropped);
                  $display("%0t: actual   sent=%b id=%h data=%h reg=%h act=%b hc=%0d drop=%b",
                           $time, got.sent, got.fid, got.fdata, got.ereg, got.active,
                           got.hcount, got.dropped);
                  errors <= errors + 1;
               end
            end
         end
      end
   end

   // receiver stalls, with a long hold-off now and then
   always @(posedge clock) begin
      if (!reset) begin
         if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_tready <= 0;
         end else if (cycles % 3000 == 1500) begin
            hold_off <= 200;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= ($urandom_range(0, 9) < 7) || stim_done;
         end
      end
   end

   task automatic write_reg(csr_index_type idx, logic [31:0] val);
      @(posedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      if (idx == CSR_INHIBIT) inhibit_cfg = val[15:0];
      else cob_cfg = val;
   endtask

   task automatic drain();
      while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   function automatic req_item_t mk(logic [1:0] k, logic [15:0] c, logic [7:0] b,
                                    logic [39:0] inf, logic [31:0] t, logic r);
      req_item_t q;
      q = {k, c, b, inf, t, r};
      return q;
   endfunction

   // mostly a small code pool so clears hit; ticks carry advancing time
   task automatic random_items(int n);
      logic [31:0] t;
      req_item_t q;
      t = $urandom;
      for (int i = 0; i < n; i++) begin
         q.kind = 2'($urandom_range(0, 3));
         q.code = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(1, 12));
         q.rbits = 8'($urandom);
         q.info = {8'($urandom), 32'($urandom)};
         t += $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 8);
         q.now = t;
         q.txr = $urandom_range(0, 4) != 0;
         pending_reqs.push_back(q);
      end
   endtask

   initial begin
      tbl_n = 0; hist_n = 0; ring_wr = 0; ring_rd = 0; quiet_until = 0;
      inhibit_cfg = INHIBIT_RESET;
      cob_cfg = COB_ID_RESET;
      repeat (5) @(posedge clock);
      reset <= 0;
      // directed: raise extremes, duplicate, full table, full ring, clears, ticks
      pending_reqs.push_back(mk(REQ_TICK, 0, 0, 0, 0, 1));
      pending_reqs.push_back(mk(REQ_RAISE, 16'hFFFF, 8'hFF, 40'hFF_FFFF_FFFF, 0, 1));
      pending_reqs.push_back(mk(REQ_RAISE, 16'hFFFF, 8'h00, 0, 0, 1));
      for (int i = 0; i < 8; i++)
         pending_reqs.push_back(mk(REQ_RAISE, 16'(i), 8'(1 << i), 40'(i * 37), 0, 0));
      pending_reqs.push_back(mk(REQ_CLEAR, 16'h1234, 0, 0, 0, 0));
      pending_reqs.push_back(mk(REQ_TICK, 3, 0, 0, 32'hFFFF_FFFF, 0));
      pending_reqs.push_back(mk(REQ_TICK, 3, 0, 0, 32'h8000_0000, 1));
      pending_reqs.push_back(mk(REQ_CLEARALL, 0, 0, 0, 0, 1));
      pending_reqs.push_back(mk(REQ_CLEARALL, 0, 0, 0, 0, 1));
      pending_reqs.push_back(mk(REQ_RAISE, 16'h1001, 8'h10, 0, 0, 1));
      pending_reqs.push_back(mk(REQ_CLEAR, 16'h1001, 0, 0, 0, 1));
      for (int i = 0; i < 8; i++)
         pending_reqs.push_back(mk(REQ_TICK, 0, 0, 0, 32'(i), 1));
      drain();
      write_reg(CSR_INHIBIT, 32'd1);
      write_reg(CSR_COB_ID, 32'h0000_07FF);
      random_items(120);
      drain();
      write_reg(CSR_INHIBIT, 32'hFFFF);
      write_reg(CSR_COB_ID, 32'h8000_0081);
      random_items(80);
      drain();
      write_reg(CSR_COB_ID, 32'h7FFF_F800);
      random_items(100);
      drain();
      write_reg(CSR_INHIBIT, 32'd25);
      write_reg(CSR_COB_ID, 32'hFFFF_FFFF);
      random_items(60);
      drain();
      write_reg(CSR_INHIBIT, 32'd0);
      write_reg(CSR_COB_ID, 32'd128);
      random_items(140);
      drain();
      stim_done = 1;
      repeat (20) @(posedge clock);
      if (errors == 0 && expected_rsps.size() == 0) $display("tb_emergency_error_producer OK");
      else $display("tb_emergency_error_producer NOT OK");
      $finish;
   end

   always @(posedge clock) begin
      if (cycles > LIMIT) begin
         $display("tb_emergency_error_producer NOT OK");
         $finish;
      end
   end

endmodule
